[hdl/afp_pkg.sv]
// Shared types, widths, register codes and reset values of the array focus phase block.
package afp_pkg;

   localparam int unsigned COLUMNS_DEFAULT    = 16;
   localparam int unsigned ROWS_DEFAULT       = 16;
   localparam int unsigned LAYERS_DEFAULT     = 2;
   localparam int unsigned PHASE_BITS_DEFAULT = 8;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam int unsigned INDEX_W    = 9;
   localparam int unsigned PITCH_W    = 18;
   localparam int unsigned COORD_W    = 21;
   localparam int unsigned ABS_W      = 19;
   localparam int unsigned SQUARE_W   = 38;
   localparam int unsigned SUM_W      = 40;
   localparam int unsigned RADICAND_W = SUM_W + 16;
   localparam int unsigned ROOT_W     = RADICAND_W / 2;
   localparam int unsigned STEP_W     = 24;
   localparam int unsigned PRODUCT_W  = ROOT_W + STEP_W;
   localparam int unsigned DIST_W     = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAVE_STEP = 3'd0,
      CSR_SPACING_X = 3'd1,
      CSR_SPACING_Z = 3'd2,
      CSR_UPPER_Y   = 3'd3,
      CSR_LOWER_Y   = 3'd4
   } afp_csr_type;

   typedef struct packed {
      logic signed [15:0]       focus_x;
      logic signed [15:0]       focus_y;
      logic signed [15:0]       focus_z;
      logic [INDEX_W-1:0]       element_index;
   } afp_req_type;

   typedef struct packed {
      logic [7:0]               phase_count;
      logic [DIST_W-1:0]        distance_units;
   } afp_rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0]        wave_step;
      logic [11:0]              spacing_x;
      logic [11:0]              spacing_z;
      logic signed [15:0]       upper_y;
      logic signed [15:0]       lower_y;
   } afp_cfg_type;

   typedef struct packed {
      logic [RADICAND_W-1:0]    radicand;
      logic                     half;
   } afp_sq_type;

   typedef struct packed {
      logic [ROOT_W-1:0]        root;
      logic                     half;
   } afp_root_type;

   localparam afp_cfg_type CFG_RESET = '{
      wave_step: 24'd122289,
      spacing_x: 12'd168,
      spacing_z: 12'd168,
      upper_y:   16'sd1600,
      lower_y:   16'sd0
   };

endpackage

[hdl/afp_geom.sv]
// Element decode, position and squared focal distance pipeline.
module afp_geom #(
   parameter int unsigned COLUMNS = afp_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS    = afp_pkg::ROWS_DEFAULT,
   parameter int unsigned LAYERS  = afp_pkg::LAYERS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  afp_pkg::afp_cfg_type cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  afp_pkg::afp_req_type in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output afp_pkg::afp_sq_type  out_word
);
   import afp_pkg::*;

   localparam int unsigned PER_LAYER   = COLUMNS * ROWS;
   localparam int unsigned ELEMENTS    = LAYERS * PER_LAYER;
   localparam int unsigned LAST_INDEX  = (ELEMENTS < (1 << INDEX_W)) ? ELEMENTS - 1
                                                                     : (1 << INDEX_W) - 1;
   localparam int unsigned HALF_START  = ELEMENTS / 2;
   localparam int unsigned RECIP_SHIFT = 20;
   localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / ROWS;
   localparam int unsigned RECIP_W     = INDEX_W + RECIP_SHIFT + 1;
   localparam int unsigned COL_W       = $clog2(COLUMNS + 1);
   localparam int unsigned ROW_W       = $clog2(ROWS + 1);
   localparam int unsigned STAGES      = 8;

   typedef struct packed {
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic signed [15:0] fz;
      logic               layer;
      logic               half;
   } afp_side_type;

   function automatic logic [ABS_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W-1:0] d;
      d = a - b;
      return ABS_W'(d[COORD_W-1] ? -d : d);
   endfunction

   function automatic logic signed [COORD_W-1:0] twice(input logic signed [15:0] v);
      return {{(COORD_W - 17){v[15]}}, v, 1'b0};
   endfunction

   logic valid_ff [STAGES];
   logic valid_src [STAGES];
   logic adv [STAGES+1];

   afp_side_type side_ff [5];
   afp_side_type side_in;

   logic [INDEX_W-1:0] idx_sat;
   logic [INDEX_W-1:0] rem0_ff, rem0_in;
   logic [INDEX_W-1:0] rem1_ff, q1_ff, q1_in;
   logic [INDEX_W-1:0] r_raw;
   logic               wrap;
   logic [COL_W-1:0]   col2_ff, col2_in;
   logic [ROW_W-1:0]   row2_ff, row2_in;
   logic [PITCH_W-1:0] cx3_ff, cx3_in, rz3_ff, rz3_in;
   logic [PITCH_W-1:0] base_x, base_z;
   logic signed [COORD_W-1:0] ex_raw;
   logic signed [COORD_W-1:0] ex4_ff, ex4_in, ey4_ff, ey4_in, ez4_ff, ez4_in;
   logic [ABS_W-1:0]    ax5_ff, ax5_in, ay5_ff, ay5_in, az5_ff, az5_in;
   logic [SQUARE_W-1:0] sqx6_ff, sqx6_in, sqy6_ff, sqy6_in, sqz6_ff, sqz6_in;
   logic [SUM_W-1:0]    sum;
   logic [RADICAND_W-1:0] radicand7_ff, radicand7_in;
   logic half5_ff, half6_ff, half7_ff;

   always_comb begin
      adv[STAGES] = out_ready;
      for (int i = STAGES - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_src[0] = in_valid;
      for (int i = 1; i < STAGES; i++) begin
         valid_src[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_src[i];
            end
         end
      end
   end

   always_comb begin
      idx_sat = (32'(in_word.element_index) >= ELEMENTS) ? INDEX_W'(LAST_INDEX)
                                                         : in_word.element_index;
      side_in.fx    = in_word.focus_x;
      side_in.fy    = in_word.focus_y;
      side_in.fz    = in_word.focus_z;
      side_in.layer = (LAYERS > 1) && (32'(idx_sat) >= PER_LAYER);
      side_in.half  = 32'(idx_sat) >= HALF_START;
      rem0_in = side_in.layer ? INDEX_W'(32'(idx_sat) - PER_LAYER) : idx_sat;
   end

   always_comb begin
      q1_in = INDEX_W'((RECIP_W'(rem0_ff) * RECIP_W'(RECIP)) >> RECIP_SHIFT);
   end

   always_comb begin
      r_raw   = rem1_ff - INDEX_W'(q1_ff * INDEX_W'(ROWS));
      wrap    = r_raw >= INDEX_W'(ROWS);
      col2_in = COL_W'(wrap ? q1_ff + INDEX_W'(1) : q1_ff);
      row2_in = ROW_W'(wrap ? r_raw - INDEX_W'(ROWS) : r_raw);
   end

   always_comb begin
      cx3_in = PITCH_W'(col2_ff) * PITCH_W'(cfg.spacing_x);
      rz3_in = PITCH_W'(row2_ff) * PITCH_W'(cfg.spacing_z);
   end

   always_comb begin
      base_x = PITCH_W'(COLUMNS - 1) * PITCH_W'(cfg.spacing_x);
      base_z = PITCH_W'(ROWS - 1) * PITCH_W'(cfg.spacing_z);
      ex_raw = $signed({3'b000, base_x}) - $signed({2'b00, cx3_ff, 1'b0});
      ex4_in = side_ff[3].layer ? -ex_raw : ex_raw;
      ez4_in = $signed({2'b00, rz3_ff, 1'b0}) - $signed({3'b000, base_z});
      ey4_in = twice(side_ff[3].layer ? cfg.lower_y : cfg.upper_y);
   end

   always_comb begin
      ax5_in = abs_diff(twice(side_ff[4].fx), ex4_ff);
      ay5_in = abs_diff(twice(side_ff[4].fy), ey4_ff);
      az5_in = abs_diff(twice(side_ff[4].fz), ez4_ff);
   end

   always_comb begin
      sqx6_in = SQUARE_W'(ax5_ff) * SQUARE_W'(ax5_ff);
      sqy6_in = SQUARE_W'(ay5_ff) * SQUARE_W'(ay5_ff);
      sqz6_in = SQUARE_W'(az5_ff) * SQUARE_W'(az5_ff);
   end

   always_comb begin
      sum          = SUM_W'(sqx6_ff) + SUM_W'(sqy6_ff) + SUM_W'(sqz6_ff);
      radicand7_in = {sum, 16'h0000};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         side_ff[0] <= side_in;
         rem0_ff    <= rem0_in;
      end
      if (adv[1]) begin
         side_ff[1] <= side_ff[0];
         rem1_ff    <= rem0_ff;
         q1_ff      <= q1_in;
      end
      if (adv[2]) begin
         side_ff[2] <= side_ff[1];
         col2_ff    <= col2_in;
         row2_ff    <= row2_in;
      end
      if (adv[3]) begin
         side_ff[3] <= side_ff[2];
         cx3_ff     <= cx3_in;
         rz3_ff     <= rz3_in;
      end
      if (adv[4]) begin
         side_ff[4] <= side_ff[3];
         ex4_ff     <= ex4_in;
         ey4_ff     <= ey4_in;
         ez4_ff     <= ez4_in;
      end
      if (adv[5]) begin
         half5_ff <= side_ff[4].half;
         ax5_ff   <= ax5_in;
         ay5_ff   <= ay5_in;
         az5_ff   <= az5_in;
      end
      if (adv[6]) begin
         half6_ff <= half5_ff;
         sqx6_ff  <= sqx6_in;
         sqy6_ff  <= sqy6_in;
         sqz6_ff  <= sqz6_in;
      end
      if (adv[7]) begin
         half7_ff     <= half6_ff;
         radicand7_ff <= radicand7_in;
      end
   end

   assign in_ready          = adv[0];
   assign out_valid         = valid_ff[STAGES-1];
   assign out_word.radicand = radicand7_ff;
   assign out_word.half     = half7_ff;

   a_rem_in_layer: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (32'(rem0_ff) < PER_LAYER))
      else $error("Element offset within its layer is out of range.");

   a_grid_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> ((32'(row2_ff) < ROWS) && (32'(col2_ff) < COLUMNS)))
      else $error("Decoded column or row is outside the grid.");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
      else $error("Stalled squared distance word changed or vanished.");

endmodule

[hdl/afp_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module afp_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  afp_pkg::afp_sq_type   in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output afp_pkg::afp_root_type out_word
);
   import afp_pkg::*;

   localparam int unsigned STEPS = ROOT_W;

   logic                  valid_ff [STEPS];
   logic [RADICAND_W-1:0] rest_ff  [STEPS];
   logic [RADICAND_W-1:0] res_ff   [STEPS];
   logic                  half_ff  [STEPS];
   logic                  adv      [STEPS+1];

   assign adv[STEPS] = out_ready;

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam logic [RADICAND_W-1:0] STEP_BIT = RADICAND_W'(1) << (2 * (STEPS - 1 - s));

      logic                  valid_src;
      logic                  half_src;
      logic [RADICAND_W-1:0] rest_src;
      logic [RADICAND_W-1:0] res_src;
      logic [RADICAND_W:0]   trial;
      logic [RADICAND_W-1:0] rest_in;
      logic [RADICAND_W-1:0] res_in;

      if (s == 0) begin : g_first
         assign valid_src = in_valid;
         assign half_src  = in_word.half;
         assign rest_src  = in_word.radicand;
         assign res_src   = '0;
      end else begin : g_next
         assign valid_src = valid_ff[s-1];
         assign half_src  = half_ff[s-1];
         assign rest_src  = rest_ff[s-1];
         assign res_src   = res_ff[s-1];
      end

      assign adv[s] = !valid_ff[s] || adv[s+1];
      assign trial  = {1'b0, res_src} + {1'b0, STEP_BIT};

      always_comb begin
         if ({1'b0, rest_src} >= trial) begin
            rest_in = rest_src - trial[RADICAND_W-1:0];
            res_in  = (res_src >> 1) + STEP_BIT;
         end else begin
            rest_in = rest_src;
            res_in  = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rest_ff[s] <= rest_in;
            res_ff[s]  <= res_in;
            half_ff[s] <= half_src;
         end
      end
   end

   assign in_ready      = adv[0];
   assign out_valid     = valid_ff[STEPS-1];
   assign out_word.root = res_ff[STEPS-1][ROOT_W-1:0];
   assign out_word.half = half_ff[STEPS-1];

endmodule

[hdl/afp_phase.sv]
// Phase scaling, half-turn offset and distance rounding with the output register.
module afp_phase #(
   parameter int unsigned PHASE_BITS = afp_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  afp_pkg::afp_cfg_type  cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  afp_pkg::afp_root_type in_word,
   output logic                  out_valid,
   input  logic                  out_ready,
   output afp_pkg::afp_rsp_type  out_word
);
   import afp_pkg::*;

   localparam int unsigned ROUND_SHIFT = 25;
   localparam int unsigned DIST_SHIFT  = 9;
   localparam int unsigned DIST_FULL_W = ROOT_W + 1 - DIST_SHIFT;

   logic                   valid0_ff, valid1_ff;
   logic                   adv0, adv1;
   logic [PRODUCT_W-1:0]   prod0_ff, prod0_in;
   logic [ROOT_W-1:0]      root0_ff;
   logic                   half0_ff;
   logic [PRODUCT_W:0]     rounded;
   logic [PHASE_BITS-1:0]  p_low;
   logic [PHASE_BITS-1:0]  turn;
   logic [PHASE_BITS-1:0]  phase;
   logic [ROOT_W:0]        root_round;
   logic [DIST_FULL_W-1:0] dist_full;
   afp_rsp_type            word1_ff, word1_in;

   assign adv1     = !valid1_ff || out_ready;
   assign adv0     = !valid0_ff || adv1;
   assign prod0_in = PRODUCT_W'(in_word.root) * PRODUCT_W'(cfg.wave_step);

   always_comb begin
      rounded    = {1'b0, prod0_ff} + ((PRODUCT_W + 1)'(1) << (ROUND_SHIFT - 1));
      p_low      = rounded[ROUND_SHIFT +: PHASE_BITS];
      turn       = half0_ff ? (PHASE_BITS'(1) << (PHASE_BITS - 1)) : '0;
      phase      = turn - p_low;
      root_round = {1'b0, root0_ff} + (ROOT_W + 1)'(256);
      dist_full  = root_round[ROOT_W:DIST_SHIFT];
      word1_in.phase_count    = 8'(phase);
      word1_in.distance_units = (dist_full > DIST_FULL_W'({DIST_W{1'b1}}))
                                ? {DIST_W{1'b1}} : dist_full[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         if (adv0) begin
            valid0_ff <= in_valid;
         end
         if (adv1) begin
            valid1_ff <= valid0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         prod0_ff <= prod0_in;
         root0_ff <= in_word.root;
         half0_ff <= in_word.half;
      end
      if (adv1) begin
         word1_ff <= word1_in;
      end
   end

   assign in_ready  = adv0;
   assign out_valid = valid1_ff;
   assign out_word  = word1_ff;

endmodule

[hdl/array_focus_phase_core.sv]
// Top level of the array focus phase block: register file and pipeline chain.
// Each word names a focal point and an element of the array; the block returns that element's
// drive phase, in counts of a full turn, and its focal distance in sixteenths of a millimetre.
// One word is accepted per clock cycle while the output is not stalled. Eight stages
// decode the element and form the squared distance, 28 stages resolve one bit of the square
// root each, and two stages scale the phase and hold the output word. Stages advance
// independently, so empty slots close up while the output is stalled. The user is to write
// registers through the csr port only while no words are in flight; the block does not
// enforce this. Indexes beyond the last register are ignored.
module array_focus_phase_core #(
   parameter int unsigned COLUMNS    = afp_pkg::COLUMNS_DEFAULT,
   parameter int unsigned ROWS       = afp_pkg::ROWS_DEFAULT,
   parameter int unsigned LAYERS     = afp_pkg::LAYERS_DEFAULT,
   parameter int unsigned PHASE_BITS = afp_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [afp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [afp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  afp_pkg::afp_req_type               req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output afp_pkg::afp_rsp_type               rsp_word
);
   import afp_pkg::*;

   afp_cfg_type  cfg_ff, cfg_in;
   logic         sq_valid, sq_ready;
   afp_sq_type   sq_word;
   logic         root_valid, root_ready;
   afp_root_type root_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WAVE_STEP: begin
               cfg_in.wave_step = csr_write_data;
            end
            CSR_SPACING_X: begin
               cfg_in.spacing_x = csr_write_data[11:0];
            end
            CSR_SPACING_Z: begin
               cfg_in.spacing_z = csr_write_data[11:0];
            end
            CSR_UPPER_Y: begin
               cfg_in.upper_y = csr_write_data[15:0];
            end
            CSR_LOWER_Y: begin
               cfg_in.lower_y = csr_write_data[15:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   afp_geom #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .LAYERS  (LAYERS)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_word),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_word  (sq_word)
   );

   afp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_word   (sq_word),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_word  (root_word)
   );

   afp_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (root_valid),
      .in_ready  (root_ready),
      .in_word   (root_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

endmodule

[tb/array_focus_phase_core_test.sv]
// Self-checking testbench for array_focus_phase_core with randomized traffic and scoreboard.
`timescale 1ns / 100ps

module array_focus_phase_core_test;
   import afp_pkg::*;

   localparam int COLUMNS       = COLUMNS_DEFAULT;
   localparam int ROWS          = ROWS_DEFAULT;
   localparam int LAYERS        = LAYERS_DEFAULT;
   localparam int PHASE_BITS    = PHASE_BITS_DEFAULT;
   localparam int ELEMENTS      = LAYERS * COLUMNS * ROWS;
   localparam int PER_LAYER     = COLUMNS * ROWS;
   localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 1;

   localparam int CSR_SPARE_FIRST = int'(CSR_LOWER_Y) + 1;
   localparam int CSR_SPARE_LAST  = (1 << CSR_INDEX_W) - 1;

   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 64;
   localparam int CYCLE_LIMIT   = 1000000;

   class focus_scoreboard;
      afp_cfg_type  regs;
      afp_rsp_type  expected_words[$];
      int           mismatch_count;

      function new();
         regs = CFG_RESET;
         mismatch_count = 0;
      endfunction

      function void apply_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_WAVE_STEP: regs.wave_step = data[STEP_W-1:0];
            CSR_SPACING_X: regs.spacing_x = data[11:0];
            CSR_SPACING_Z: regs.spacing_z = data[11:0];
            CSR_UPPER_Y:   regs.upper_y   = data[15:0];
            CSR_LOWER_Y:   regs.lower_y   = data[15:0];
            default: ;
         endcase
      endfunction

      function longint unsigned floor_root(longint unsigned value);
         longint unsigned acc;
         longint unsigned trial;
         acc = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= value) begin
               acc = trial;
            end
         end
         return acc;
      endfunction

      function afp_rsp_type predict_phase(afp_req_type w);
         afp_rsp_type      result;
         int               idx;
         int               layer;
         int               col;
         int               row;
         bit               second_half;
         longint           pitch_x;
         longint           pitch_z;
         longint           ex2;
         longint           ey2;
         longint           ez2;
         longint           dx;
         longint           dy;
         longint           dz;
         longint unsigned  radicand;
         longint unsigned  root;
         longint unsigned  turns;
         longint unsigned  phase;
         longint unsigned  distance;
         idx = int'(w.element_index);
         if (idx >= ELEMENTS) begin
            idx = ELEMENTS - 1;
         end
         second_half = idx >= ELEMENTS / 2;
         layer = idx / PER_LAYER;
         col = (idx % PER_LAYER) / ROWS;
         row = idx % ROWS;
         pitch_x = longint'(regs.spacing_x);
         pitch_z = longint'(regs.spacing_z);
         ex2 = (COLUMNS - 1) * pitch_x - 2 * col * pitch_x;
         if (layer == 1) begin
            ex2 = -ex2;
         end
         ez2 = 2 * row * pitch_z - (ROWS - 1) * pitch_z;
         ey2 = 2 * ((layer == 0) ? longint'(regs.upper_y) : longint'(regs.lower_y));
         dx = 2 * longint'(w.focus_x) - ex2;
         dy = 2 * longint'(w.focus_y) - ey2;
         dz = 2 * longint'(w.focus_z) - ez2;
         radicand = longint'(dx * dx + dy * dy + dz * dz) << 16;
         root = floor_root(radicand);
         turns = (root * longint'(regs.wave_step) + (64'd1 << 24)) >> 25;
         phase = 64'd0 - turns;
         if (second_half) begin
            phase += 64'd1 << (PHASE_BITS - 1);
         end
         phase &= (64'd1 << PHASE_BITS) - 1;
         distance = (root + 256) >> 9;
         if (distance > DIST_LIMIT) begin
            distance = DIST_LIMIT;
         end
         result.phase_count = phase[7:0];
         result.distance_units = distance[DIST_W-1:0];
         return result;
      endfunction

      function void note_request(afp_req_type w);
         expected_words = {expected_words, predict_phase(w)};
      endfunction

      function void check_response(afp_rsp_type got);
         afp_rsp_type want;
         if (expected_words.size() == 0) begin
            $error("Unexpected result word: phase_count %0d, distance_units %0d",
                   got.phase_count, got.distance_units);
            mismatch_count++;
            return;
         end
         want = expected_words.pop_front();
         if (got.phase_count !== want.phase_count) begin
            $error("phase_count: expected %0d, actual %0d", want.phase_count, got.phase_count);
            mismatch_count++;
         end
         if (got.distance_units !== want.distance_units) begin
            $error("distance_units: expected %0d, actual %0d",
                   want.distance_units, got.distance_units);
            mismatch_count++;
         end
      endfunction

      function int pending_count();
         return expected_words.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_write_data;
   logic                    req_valid;
   logic                    req_ready;
   afp_req_type             req_word;
   logic                    rsp_valid;
   logic                    rsp_ready;
   afp_rsp_type             rsp_word;

   focus_scoreboard board;
   int  sender_quiet;
   int  receiver_quiet;
   bit  hold_output;
   int  cycle_count;

   array_focus_phase_core #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS),
      .LAYERS(LAYERS),
      .PHASE_BITS(PHASE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic int gap_length(inout int quiet);
      int roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         quiet = $urandom_range(80, 20);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic signed [15:0] random_coordinate();
      case ($urandom_range(4))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic afp_req_type random_word();
      afp_req_type w;
      int mode;
      mode = $urandom_range(99);
      if (mode < 35) begin
         w.focus_x = 16'($urandom);
         w.focus_y = 16'($urandom);
         w.focus_z = 16'($urandom);
      end else if (mode < 85) begin
         w.focus_x = 16'(int'($urandom_range(6000)) - 3000);
         w.focus_y = 16'(int'($urandom_range(8000)) - 2000);
         w.focus_z = 16'(int'($urandom_range(6000)) - 3000);
      end else begin
         w.focus_x = random_coordinate();
         w.focus_y = random_coordinate();
         w.focus_z = random_coordinate();
      end
      if ($urandom_range(9) != 0) begin
         w.element_index = INDEX_W'($urandom_range(ELEMENTS - 1));
      end else begin
         case ($urandom_range(3))
            0: w.element_index = '0;
            1: w.element_index = INDEX_W'(ELEMENTS / 2 - 1);
            2: w.element_index = INDEX_W'(ELEMENTS / 2);
            default: w.element_index = INDEX_W'(ELEMENTS - 1);
         endcase
      end
      return w;
   endfunction

   task automatic send_word(afp_req_type w);
      int gap;
      gap = gap_length(sender_quiet);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      board.note_request(w);
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = data;
      board.apply_register(index, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      receiver_quiet = 0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = gap_length(receiver_quiet);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_word);
      end
   end

   initial begin
      afp_req_type  w;
      afp_cfg_type  setting;
      int           probe_index[8];
      logic signed [15:0] corner[3];
      board = new();
      sender_quiet = 0;
      hold_output = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      probe_index = '{0, ROWS - 1, (COLUMNS - 1) * ROWS, ELEMENTS / 2 - 1, ELEMENTS / 2,
                      ELEMENTS / 2 + ROWS - 1, ELEMENTS - ROWS, ELEMENTS - 1};
      corner = '{16'sh8000, 16'sh7FFF, 16'sh0000};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Corners of the focal space against the corner elements of both layers.
      foreach (corner[c]) begin
         foreach (probe_index[k]) begin
            w.focus_x = corner[c];
            w.focus_y = corner[c];
            w.focus_z = corner[c];
            w.element_index = INDEX_W'(probe_index[k]);
            send_word(w);
         end
      end
      // A focal point sitting exactly on the first element gives zero distance.
      w.focus_x = 16'((COLUMNS - 1) * int'(CFG_RESET.spacing_x) / 2);
      w.focus_y = CFG_RESET.upper_y;
      w.focus_z = 16'(-(ROWS - 1) * int'(CFG_RESET.spacing_z) / 2);
      w.element_index = '0;
      send_word(w);

      for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
         req_valid = 1'b0;
         while (board.pending_count() != 0) @(negedge clock);
         case (phase)
            1: setting = '{wave_step: '1, spacing_x: '1, spacing_z: '1,
                           upper_y: 16'sh7FFF, lower_y: 16'sh8000};
            2: setting = '{wave_step: '0, spacing_x: '0, spacing_z: '0,
                           upper_y: 16'sh8000, lower_y: 16'sh7FFF};
            4: setting = '{wave_step: 24'($urandom_range(200000, 60000)),
                           spacing_x: 12'($urandom_range(300, 100)),
                           spacing_z: 12'($urandom_range(300, 100)),
                           upper_y: 16'($urandom_range(3000, 1000)),
                           lower_y: 16'(int'($urandom_range(400)) - 200)};
            default: setting = '{wave_step: 24'($urandom), spacing_x: 12'($urandom),
                                 spacing_z: 12'($urandom), upper_y: 16'($urandom),
                                 lower_y: 16'($urandom)};
         endcase
         write_register(CSR_INDEX_W'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)),
                        CSR_DATA_W'($urandom));
         write_register(CSR_WAVE_STEP, setting.wave_step);
         write_register(CSR_SPACING_X, {12'($urandom), setting.spacing_x});
         write_register(CSR_SPACING_Z, {12'($urandom), setting.spacing_z});
         write_register(CSR_UPPER_Y, {8'($urandom), setting.upper_y});
         write_register(CSR_LOWER_Y, {8'($urandom), setting.lower_y});
         if (phase == 3 || phase == 6) begin
            hold_output = 1'b1;
         end
         repeat (PHASE_ITEMS) send_word(random_word());
      end
      req_valid = 1'b0;

      while (board.pending_count() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_count() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
